// File: rtl/rbvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbvp_pkg
// Shared constants for the radial brush vertex push pipeline: config register
// codes, fixed datapath widths and the falloff series denominators.
// ----------------------------------------------------------------------------
package rbvp_pkg;

    // config port
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 3'd4;

    // datapath widths
    localparam int RAD_W  = 23;           // radius and in-box axis distance
    localparam int STR_W  = 24;           // push strength
    localparam int SQ_W   = 2 * RAD_W;    // one squared axis distance
    localparam int DSQ_W  = SQ_W + 2;     // sum of three squares
    localparam int FRAC_W = 16;           // distance root carries 8 fraction bits
    localparam int D_W    = RAD_W + 8;    // distance in Q8
    localparam int F_W    = 17;           // falloff in Q16, up to 1.0
    localparam int P_W    = STR_W + F_W;  // strength times falloff
    localparam int A_W    = 32;           // push distance in Q8
    localparam int MN_W   = A_W + RAD_W + 1;
    localparam int M_W    = 24;           // per-axis offset magnitude
    localparam int DZ_W   = 24;           // near-centre z offset magnitude

    localparam logic [DSQ_W-1:0] NEAR_SQ = DSQ_W'(104);

    // pi in Q30 and Taylor series denominators (2n)(2n+1)
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned FALL_DEN [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

endpackage
`default_nettype wire

// File: rtl/rbvp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbvp_sqrt
// Pipelined integer square root, one result bit per stage, RW stages.
// ----------------------------------------------------------------------------
module rbvp_sqrt #(
    parameter int RW = 31
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [2*RW-1:0]   i_n,
    output logic      [RW-1:0]     o_root
);

    localparam int NW = 2 * RW;
    localparam int CW = NW + 1;

    logic [NW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [NW-1:0] n_rem  [RW];
    logic [RW-1:0] n_root [RW];

    // each stage tries the next lower root bit against the remainder n - root^2
    always_comb begin
        logic [NW-1:0] v_rem;
        logic [RW-1:0] v_root;
        logic [CW-1:0] v_trial;
        for (int s = 0; s < RW; s++) begin
            v_rem   = (s == 0) ? i_n : r_rem[s-1];
            v_root  = (s == 0) ? '0 : r_root[s-1];
            v_trial = (CW'(v_root) << (RW - s)) + (CW'(1) << (2 * (RW - 1 - s)));
            if (CW'(v_rem) >= v_trial) begin
                n_rem[s]  = NW'(CW'(v_rem) - v_trial);
                n_root[s] = v_root | (RW'(1) << (RW - 1 - s));
            end else begin
                n_rem[s]  = v_rem;
                n_root[s] = v_root;
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < RW; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule
`default_nettype wire

// File: rtl/rbvp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbvp_div
// Pipelined restoring divider, one quotient bit per stage, QUO_W stages.
// The caller guarantees that the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module rbvp_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 31,
    parameter int QUO_W = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic      [QUO_W-1:0]  o_quo
);

    localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [CW-1:0]    r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [CW-1:0]    n_rem [QUO_W];
    logic [DEN_W-1:0] n_den [QUO_W];
    logic [QUO_W-1:0] n_quo [QUO_W];

    // each stage subtracts the shifted divisor when it fits
    always_comb begin
        logic [CW-1:0]    v_rem;
        logic [CW-1:0]    v_sub;
        logic [DEN_W-1:0] v_den;
        logic [QUO_W-1:0] v_quo;
        for (int s = 0; s < QUO_W; s++) begin
            v_rem = (s == 0) ? CW'(i_num) : r_rem[s-1];
            v_den = (s == 0) ? i_den : r_den[s-1];
            v_quo = (s == 0) ? '0 : r_quo[s-1];
            v_sub = CW'(v_den) << (QUO_W - 1 - s);
            n_den[s] = v_den;
            if (v_rem >= v_sub) begin
                n_rem[s] = v_rem - v_sub;
                n_quo[s] = v_quo | (QUO_W'(1) << (QUO_W - 1 - s));
            end else begin
                n_rem[s] = v_rem;
                n_quo[s] = v_quo;
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QUO_W; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= n_den[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule
`default_nettype wire

// File: rtl/radial_brush_vertex_push.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radial_brush_vertex_push
// Spherical sculpt brush with raised-cosine falloff: pushes each vertex inside
// the sphere off the centre (in if strength < 0), saturating at the coordinate range.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  vertex    i_valid / o_ready    i_vertex_x, i_vertex_y, i_vertex_z
//  result    o_valid / i_ready    o_moved_x, o_moved_y, o_moved_z, o_inside_brush
//  config    i_cfg_we             i_cfg_idx, i_cfg_data
//
//  one vertex per cycle; the path runs through the input stages, the bit-per-stage
//  root, the index divider and the offset dividers
//  every stage holds while the result register is full and not taken
//  synchronous active-low reset clears config and all valid bits
// ----------------------------------------------------------------------------
module radial_brush_vertex_push #(
    parameter int COORD_BITS          = 24,
    parameter int FALLOFF_TABLE_DEPTH = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rbvp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rbvp_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [COORD_BITS-1:0]        i_vertex_x,
    input  wire logic signed [COORD_BITS-1:0]        i_vertex_y,
    input  wire logic signed [COORD_BITS-1:0]        i_vertex_z,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [COORD_BITS-1:0]             o_moved_x,
    output logic signed [COORD_BITS-1:0]             o_moved_y,
    output logic signed [COORD_BITS-1:0]             o_moved_z,
    output logic                                     o_inside_brush
);

    localparam int RAD_W = rbvp_pkg::RAD_W;
    localparam int D_W   = rbvp_pkg::D_W;
    localparam int QW    = $clog2(FALLOFF_TABLE_DEPTH + 1);
    localparam int LUT_N = 2 ** QW;
    localparam int NIW   = D_W + QW;
    localparam int DFW   = ((COORD_BITS > 24) ? COORD_BITS : 24) + 1;
    localparam int SUMW  = ((COORD_BITS > 26) ? COORD_BITS : 26) + 1;

    // ages counted from the distance stage register
    localparam int A_D  = D_W;                 // root out
    localparam int A_IX = A_D + 1 + QW;        // falloff index out
    localparam int A_F  = A_IX + 1;            // falloff value
    localparam int A_A  = A_F + 2;             // push distance
    localparam int A_M  = A_A + 1 + rbvp_pkg::M_W; // offset magnitudes
    localparam int T    = A_M + 1;             // result register
    localparam int NST  = 3 + T;

    localparam logic signed [SUMW-1:0] SAT_HI =
        SUMW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

    // falloff in Q16 for index idx, evaluated at elaboration
    function automatic logic [rbvp_pkg::F_W-1:0] falloff_q16(input int unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned s;
        longint          sum;
        x    = (rbvp_pkg::PI_Q30 * longint'(idx)) / (2 * FALLOFF_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 0; n < 8; n++) begin
            term = ((term * x2) >> 30) / rbvp_pkg::FALL_DEN[n];
            if ((n % 2) == 0) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        s = longint'(sum);
        return rbvp_pkg::F_W'((s * s + (64'd1 << 43)) >> 44);
    endfunction

    logic [rbvp_pkg::F_W-1:0] w_lut [LUT_N];
    for (genvar g = 0; g < LUT_N; g++) begin : g_lut
        localparam logic [rbvp_pkg::F_W-1:0] FV =
            (g <= FALLOFF_TABLE_DEPTH) ? falloff_q16(g) : '0;
        assign w_lut[g] = FV;
    end

    // ------------------------------------------------------------------------
    // configuration registers
    logic signed [23:0]             r_brush [3];
    logic        [RAD_W-1:0]        r_radius;
    logic signed [rbvp_pkg::STR_W-1:0] r_strength;
    logic        [rbvp_pkg::SQ_W-1:0]  r_rsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brush[0] <= '0;
            r_brush[1] <= '0;
            r_brush[2] <= '0;
            r_radius   <= '0;
            r_strength <= '0;
            r_rsq      <= '0;
        end else begin
            r_rsq <= r_radius * r_radius;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rbvp_pkg::CFG_BRUSH_X:  r_brush[0] <= i_cfg_data;
                    rbvp_pkg::CFG_BRUSH_Y:  r_brush[1] <= i_cfg_data;
                    rbvp_pkg::CFG_BRUSH_Z:  r_brush[2] <= i_cfg_data;
                    rbvp_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[RAD_W-1:0];
                    rbvp_pkg::CFG_STRENGTH: r_strength <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // pipeline advance and valid line
    logic            w_en;
    logic [NST:1]    r_vld;

    assign w_en    = !r_vld[NST] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-1:1], i_valid};
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: axis differences, magnitudes, bounding box
    logic signed [COORD_BITS-1:0] w_vin [3];
    logic signed [DFW-1:0]        w_diff [3];
    logic        [DFW-1:0]        w_ad [3];
    logic                         w_box;

    assign w_vin[0] = i_vertex_x;
    assign w_vin[1] = i_vertex_y;
    assign w_vin[2] = i_vertex_z;

    always_comb begin
        w_box = 1'b1;
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = DFW'(w_vin[k]) - DFW'(r_brush[k]);
            w_ad[k]   = w_diff[k][DFW-1] ? DFW'(-w_diff[k]) : DFW'(w_diff[k]);
            if (w_ad[k] > DFW'(r_radius)) w_box = 1'b0;
        end
    end

    logic signed [COORD_BITS-1:0] r1_v [3];
    logic        [2:0]            r1_neg;
    logic        [RAD_W-1:0]      r1_ad [3];
    logic                         r1_box;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_v[k]   <= w_vin[k];
                r1_neg[k] <= w_diff[k][DFW-1];
                r1_ad[k]  <= w_ad[k][RAD_W-1:0];
            end
            r1_box <= w_box;
        end
    end

    // stage 2: squares
    logic signed [COORD_BITS-1:0]     r2_v [3];
    logic        [2:0]                r2_neg;
    logic        [RAD_W-1:0]          r2_ad [3];
    logic        [rbvp_pkg::SQ_W-1:0] r2_sq [3];
    logic                             r2_box;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r2_v[k]  <= r1_v[k];
                r2_ad[k] <= r1_ad[k];
                r2_sq[k] <= r1_ad[k] * r1_ad[k];
            end
            r2_neg <= r1_neg;
            r2_box <= r1_box;
        end
    end

    // stage 3: squared distance, inside and near-centre tests
    logic [rbvp_pkg::DSQ_W-1:0] w_dsq;
    logic                       w_inside;
    logic                       w_near;

    assign w_dsq    = rbvp_pkg::DSQ_W'(r2_sq[0]) + rbvp_pkg::DSQ_W'(r2_sq[1])
                    + rbvp_pkg::DSQ_W'(r2_sq[2]);
    assign w_inside = r2_box && (w_dsq < rbvp_pkg::DSQ_W'(r_rsq));
    assign w_near   = w_dsq <= rbvp_pkg::NEAR_SQ;

    logic [rbvp_pkg::SQ_W-1:0]    r3_dsq;
    // side lines carry the per-vertex context along the long stages
    logic signed [COORD_BITS-1:0] r_sv   [T][3];
    logic        [2:0]            r_sneg [T];
    logic        [RAD_W-1:0]      r_sad  [T][3];
    logic                         r_sin  [T];
    logic                         r_snr  [T];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_dsq    <= w_dsq[rbvp_pkg::SQ_W-1:0];
            r_sv[0]   <= r2_v;
            r_sneg[0] <= r2_neg;
            r_sad[0]  <= r2_ad;
            r_sin[0]  <= w_inside;
            r_snr[0]  <= w_near;
            for (int a = 1; a < T; a++) begin
                r_sv[a]   <= r_sv[a-1];
                r_sneg[a] <= r_sneg[a-1];
                r_sad[a]  <= r_sad[a-1];
                r_sin[a]  <= r_sin[a-1];
                r_snr[a]  <= r_snr[a-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // distance in Q8
    logic [D_W-1:0] w_dist;

    rbvp_sqrt #(
        .RW (D_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_n    ({r3_dsq, {rbvp_pkg::FRAC_W{1'b0}}}),
        .o_root (w_dist)
    );

    // falloff index numerator, distance delay line
    logic [D_W-1:0] w_r8;
    logic [D_W-1:0] w_rgap;
    logic [NIW-1:0] r_nidx;
    logic [D_W-1:0] r_dl [A_A-A_D+1];

    assign w_r8   = {r_radius, 8'b0};
    assign w_rgap = w_r8 - w_dist;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nidx   <= NIW'(NIW'(w_rgap) * NIW'(FALLOFF_TABLE_DEPTH));
            r_dl[0]  <= w_dist;
            for (int a = 1; a <= A_A - A_D; a++) r_dl[a] <= r_dl[a-1];
        end
    end

    logic [QW-1:0] w_idx;

    rbvp_div #(
        .NUM_W (NIW),
        .DEN_W (D_W),
        .QUO_W (QW)
    ) u_div_idx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_nidx),
        .i_den (w_r8),
        .o_quo (w_idx)
    );

    // falloff lookup, strength product, rounding
    logic [rbvp_pkg::STR_W-1:0] w_smag;
    logic [rbvp_pkg::F_W-1:0]   r_f;
    logic [rbvp_pkg::P_W-1:0]   r_p;
    logic [rbvp_pkg::P_W:0]     w_pa;
    logic [rbvp_pkg::P_W:0]     w_pz;
    logic [rbvp_pkg::A_W-1:0]   r_a;
    logic [rbvp_pkg::DZ_W-1:0]  r_dzl [A_M-A_A+1];

    assign w_smag = r_strength[rbvp_pkg::STR_W-1] ? rbvp_pkg::STR_W'(-r_strength)
                                                   : rbvp_pkg::STR_W'(r_strength);
    assign w_pa   = {1'b0, r_p} + (rbvp_pkg::P_W + 1)'(128);
    assign w_pz   = {1'b0, r_p} + (rbvp_pkg::P_W + 1)'(32768);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f      <= w_lut[w_idx];
            r_p      <= w_smag * r_f;
            r_a      <= w_pa[rbvp_pkg::A_W+7:8];
            r_dzl[0] <= w_pz[rbvp_pkg::DZ_W+15:16];
            for (int a = 1; a <= A_M - A_A; a++) r_dzl[a] <= r_dzl[a-1];
        end
    end

    // offset numerators: push distance times axis distance, plus half divisor
    logic [rbvp_pkg::MN_W-1:0] r_num [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= rbvp_pkg::MN_W'(r_a) * rbvp_pkg::MN_W'(r_sad[A_A][k])
                          + rbvp_pkg::MN_W'(r_dl[A_A-A_D-1] >> 1);
            end
        end
    end

    logic [rbvp_pkg::M_W-1:0] w_mag [3];

    for (genvar k = 0; k < 3; k++) begin : g_off_div
        rbvp_div #(
            .NUM_W (rbvp_pkg::MN_W),
            .DEN_W (D_W),
            .QUO_W (rbvp_pkg::M_W)
        ) u_div_off (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_num[k]),
            .i_den (r_dl[A_A-A_D]),
            .o_quo (w_mag[k])
        );
    end

    // ------------------------------------------------------------------------
    // signed offsets, add and saturate
    logic signed [SUMW-1:0] w_sat [3];

    always_comb begin
        logic signed [SUMW-1:0] v_off;
        logic signed [SUMW-1:0] v_sum;
        for (int k = 0; k < 3; k++) begin
            v_off = '0;
            if (r_sin[A_M]) begin
                if (r_snr[A_M]) begin
                    if (k == 2) begin
                        v_off = r_strength[rbvp_pkg::STR_W-1]
                              ? -SUMW'(r_dzl[A_M-A_A]) : SUMW'(r_dzl[A_M-A_A]);
                    end
                end else begin
                    v_off = (r_strength[rbvp_pkg::STR_W-1] ^ r_sneg[A_M][k])
                          ? -SUMW'(w_mag[k]) : SUMW'(w_mag[k]);
                end
            end
            v_sum = SUMW'(r_sv[A_M][k]) + v_off;
            if (v_sum > SAT_HI)      w_sat[k] = SAT_HI;
            else if (v_sum < SAT_LO) w_sat[k] = SAT_LO;
            else                     w_sat[k] = v_sum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_moved_x      <= w_sat[0][COORD_BITS-1:0];
            o_moved_y      <= w_sat[1][COORD_BITS-1:0];
            o_moved_z      <= w_sat[2][COORD_BITS-1:0];
            o_inside_brush <= r_sin[A_M];
        end
    end

endmodule
`default_nettype wire

// File: rtl/rbvp_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbvp_chk
// Port-level checks for the brush pipeline, bound onto the top level.
// ----------------------------------------------------------------------------
module rbvp_chk #(
    parameter int COORD_BITS = 24
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_ready,
    input wire logic                         o_valid,
    input wire logic                         i_ready,
    input wire logic signed [COORD_BITS-1:0] o_moved_x,
    input wire logic signed [COORD_BITS-1:0] o_moved_y,
    input wire logic signed [COORD_BITS-1:0] o_moved_z,
    input wire logic                         o_inside_brush
);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_moved_x) && $stable(o_moved_y)
                                && $stable(o_moved_z) && $stable(o_inside_brush))
        else $error("result payload changed while stalled");

    // an empty result register never blocks the input side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with no pending result");

    // reset leaves no result offered
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind radial_brush_vertex_push rbvp_chk #(.COORD_BITS(COORD_BITS)) u_rbvp_chk (.*);
`default_nettype wire

// File: verif/tb_radial_brush_vertex_push.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radial_brush_vertex_push
// Self-checking bench for the radial brush vertex push block. A directed table
// covers the zero-radius reset state, the near-centre push, the sphere and box
// boundaries and saturation. Random phases follow with varied brush settings.
// Every result is compared in order with its table entry or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_radial_brush_vertex_push;

    localparam int DEPTH = 1024;
    localparam int PIPE_DRAIN = 90;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [rbvp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam longint CMAX = 64'sd8388607;
    localparam longint CMIN = -64'sd8388608;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic               in_brush;
    } t_moved;

    typedef struct {
        int                 grp;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] vz;
        bit                 typed;
        t_moved             res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [rbvp_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [rbvp_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [23:0] i_vertex_x = '0;
    logic signed [23:0] i_vertex_y = '0;
    logic signed [23:0] i_vertex_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [23:0] o_moved_x, o_moved_y, o_moved_z;
    logic o_inside_brush;

    // brush settings mirrored in the bench
    logic signed [23:0] brush_x = '0, brush_y = '0, brush_z = '0, brush_str = '0;
    logic [22:0] brush_rad = '0;

    t_moved pending_moves[$];
    int errors = 0;
    int cycles = 0;
    bit hold_ready = 1'b0;
    bit no_idle = 1'b0;

    radial_brush_vertex_push i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y), .i_vertex_z(i_vertex_z),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_moved_x(o_moved_x), .o_moved_y(o_moved_y), .o_moved_z(o_moved_z),
        .o_inside_brush(o_inside_brush)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("radial_brush_vertex_push verification failed");
            $finish;
        end
    end

    // bit-serial square root, floor
    function automatic longint unsigned dist_root(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // raised-cosine falloff in Q16 via sin^2 of half angle
    function automatic longint unsigned cos_falloff(longint unsigned step);
        longint unsigned ang, ang2, term, s;
        longint acc;
        ang = (rbvp_pkg::PI_Q30 * step) / (2 * DEPTH);
        ang2 = (ang * ang) >> 30;
        term = ang;
        acc = ang;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * ang2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
        s = acc;
        return (s * s + (64'd1 << 43)) >> 44;
    endfunction

    function automatic logic signed [23:0] clamp_coord(longint v);
        if (v > CMAX) v = CMAX;
        if (v < CMIN) v = CMIN;
        return v[23:0];
    endfunction

    // expected vertex after the brush pass
    function automatic t_moved predict_move(logic signed [23:0] vx, logic signed [23:0] vy,
                                            logic signed [23:0] vz);
        longint vv[3], diff[3], off[3];
        longint unsigned ad[3], r, dsq, sm, d8, r8, step, p, a, m;
        longint st;
        bit in_sph;
        t_moved res;
        vv[0] = vx; vv[1] = vy; vv[2] = vz;
        diff[0] = vv[0] - longint'(brush_x);
        diff[1] = vv[1] - longint'(brush_y);
        diff[2] = vv[2] - longint'(brush_z);
        r = brush_rad;
        in_sph = 1'b1;
        dsq = 0;
        for (int k = 0; k < 3; k++) begin
            off[k] = 0;
            ad[k] = diff[k] < 0 ? -diff[k] : diff[k];
            if (ad[k] > r) in_sph = 1'b0;
        end
        if (in_sph) begin
            for (int k = 0; k < 3; k++) dsq += ad[k] * ad[k];
            if (dsq >= r * r) in_sph = 1'b0;
        end
        if (in_sph) begin
            st = brush_str;
            sm = st < 0 ? -st : st;
            d8 = dist_root(dsq << 16);
            r8 = r << 8;
            step = ((r8 - d8) * DEPTH) / r8;
            p = sm * cos_falloff(step);
            if (dsq <= 104) begin
                m = (p + 32768) >> 16;
                off[2] = st < 0 ? -longint'(m) : longint'(m);
            end else begin
                a = (p + 128) >> 8;
                for (int k = 0; k < 3; k++) begin
                    m = (a * ad[k] + d8 / 2) / d8;
                    off[k] = ((st < 0) != (diff[k] < 0)) ? -longint'(m) : longint'(m);
                end
            end
        end
        res.x = clamp_coord(vv[0] + off[0]);
        res.y = clamp_coord(vv[1] + off[1]);
        res.z = clamp_coord(vv[2] + off[2]);
        res.in_brush = in_sph;
        return res;
    endfunction

    // register write at the falling edge, enable left high for the caller to drop
    task automatic write_reg(logic [rbvp_pkg::CFG_IDX_W-1:0] idx, longint value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[rbvp_pkg::CFG_W-1:0];
        case (idx)
            rbvp_pkg::CFG_BRUSH_X:  brush_x = value[23:0];
            rbvp_pkg::CFG_BRUSH_Y:  brush_y = value[23:0];
            rbvp_pkg::CFG_BRUSH_Z:  brush_z = value[23:0];
            rbvp_pkg::CFG_RADIUS:   brush_rad = value[22:0];
            rbvp_pkg::CFG_STRENGTH: brush_str = value[23:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // wait for all results and pipeline drain, then load a brush
    task automatic load_brush(longint bx, longint by, longint bz, longint rad, longint str);
        wait (pending_moves.size() == 0);
        repeat (PIPE_DRAIN) @(negedge i_clk);
        write_reg(rbvp_pkg::CFG_BRUSH_X, bx);
        write_reg(rbvp_pkg::CFG_BRUSH_Y, by);
        write_reg(rbvp_pkg::CFG_BRUSH_Z, bz);
        write_reg(rbvp_pkg::CFG_RADIUS, rad);
        write_reg(rbvp_pkg::CFG_STRENGTH, str);
        write_reg(CFG_UNUSED, longint'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // offer one vertex and hold it until the transaction completes
    task automatic send_vertex(logic signed [23:0] vx, logic signed [23:0] vy,
                               logic signed [23:0] vz, bit typed, t_moved res);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_vertex_x <= vx;
        i_vertex_y <= vy;
        i_vertex_z <= vz;
        do @(posedge i_clk); while (!o_ready);
        pending_moves.push_back(typed ? res : predict_move(vx, vy, vz));
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        t_moved exp_m;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_ready) begin
                hold_ready = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (pending_moves.size() == 0) begin
                errors++;
                $display("%0t: unexpected result x %0d y %0d z %0d inside %0b", $time,
                         o_moved_x, o_moved_y, o_moved_z, o_inside_brush);
            end else begin
                exp_m = pending_moves.pop_front();
                check_field("moved_x", exp_m.x, o_moved_x);
                check_field("moved_y", exp_m.y, o_moved_y);
                check_field("moved_z", exp_m.z, o_moved_z);
                check_field("inside_brush", exp_m.in_brush, o_inside_brush);
            end
        end
    end

    // directed table: group 0 runs at reset settings with typed results
    t_row directed[] = '{
        '{0, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1, '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0}},
        '{0, 24'sh800000, 24'sh800000, 24'sh800000, 1, '{24'sh800000, 24'sh800000, 24'sh800000, 0}},
        '{0, 24'sh0, 24'sh0, 24'sh0, 1, '{24'sh0, 24'sh0, 24'sh0, 0}},
        '{0, 24'sh5, 24'sh0, 24'sh0, 1, '{24'sh5, 24'sh0, 24'sh0, 0}},
        '{1, 24'sh0, 24'sh0, 24'sh0, 0, '{0, 0, 0, 0}},
        '{1, 24'sd10, 24'sh0, 24'sh0, 0, '{0, 0, 0, 0}},
        '{1, 24'sh0, 24'sd10, 24'sd2, 0, '{0, 0, 0, 0}},
        '{1, 24'sd11, 24'sh0, 24'sh0, 0, '{0, 0, 0, 0}},
        '{1, 24'sd2048, 24'sh0, 24'sh0, 0, '{0, 0, 0, 0}},
        '{1, 24'sh0, -24'sd2048, 24'sh0, 0, '{0, 0, 0, 0}},
        '{1, 24'sd4095, 24'sh0, 24'sh0, 0, '{0, 0, 0, 0}},
        '{1, 24'sd4096, 24'sh0, 24'sh0, 1, '{24'sd4096, 24'sh0, 24'sh0, 0}},
        '{1, 24'sd3000, 24'sd3000, 24'sh0, 1, '{24'sd3000, 24'sd3000, 24'sh0, 0}},
        '{1, 24'sd5000, 24'sh0, 24'sh0, 1, '{24'sd5000, 24'sh0, 24'sh0, 0}},
        '{1, -24'sd1, -24'sd1, -24'sd1, 0, '{0, 0, 0, 0}},
        '{2, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0, '{0, 0, 0, 0}},
        '{2, 24'sh7fff00, 24'sh7fffff, 24'sh7ffff0, 0, '{0, 0, 0, 0}},
        '{2, 24'sh0, 24'sh7fffff, 24'sh7fffff, 0, '{0, 0, 0, 0}},
        '{3, 24'sh800000, 24'sh800000, 24'sh800000, 0, '{0, 0, 0, 0}},
        '{3, 24'sh800100, 24'sh800000, 24'sh800050, 0, '{0, 0, 0, 0}},
        '{3, 24'sh7fffff, 24'sh800000, 24'sh800000, 1,
          '{24'sh7fffff, 24'sh800000, 24'sh800000, 0}}
    };

    // stimulus
    initial begin
        int grp;
        longint span, rad;
        logic signed [23:0] vx, vy, vz;
        t_moved none;
        none = '{0, 0, 0, 0};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        grp = 0;
        foreach (directed[n]) begin
            if (directed[n].grp != grp) begin
                grp = directed[n].grp;
                i_valid <= 1'b0;
                case (grp)
                    1: load_brush(0, 0, 0, 4096, 2048);
                    2: load_brush(CMAX, CMAX, CMAX, 64'd8388607, CMAX);
                    default: load_brush(CMIN, CMIN, CMIN, 64'd8388607, CMIN);
                endcase
            end
            send_vertex(directed[n].vx, directed[n].vy, directed[n].vz,
                        directed[n].typed, directed[n].res);
        end

        // random phases with varied brush settings
        for (int ph = 0; ph < 10; ph++) begin
            i_valid <= 1'b0;
            case (ph)
                0, 1: rad = longint'($urandom_range(0, 300));
                7: rad = 64'd8388607;
                8: rad = longint'($urandom_range(1, 8388607));
                default: rad = longint'($urandom_range(0, 200000));
            endcase
            load_brush(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                       longint'($signed(24'($urandom))), rad,
                       ph == 8 ? CMIN : ph == 9 ? CMAX : longint'($signed(24'($urandom))));
            no_idle = (ph == 5);
            if (ph == 3) hold_ready = 1'b1;
            span = rad + rad / 4 + 1;
            for (int n = 0; n < 95; n++) begin
                if (ph == 2 && n == 40) begin
                    i_valid <= 1'b0;
                    wait (pending_moves.size() == 0);
                    @(negedge i_clk);
                end
                if ($urandom_range(0, 9) < 7) begin
                    vx = 24'(longint'(brush_x) + longint'($urandom_range(0, 2 * span)) - span);
                    vy = 24'(longint'(brush_y) + longint'($urandom_range(0, 2 * span)) - span);
                    vz = 24'(longint'(brush_z) + longint'($urandom_range(0, 2 * span)) - span);
                end else begin
                    vx = 24'($urandom);
                    vy = 24'($urandom);
                    vz = 24'($urandom);
                end
                send_vertex(vx, vy, vz, 1'b0, none);
            end
        end
        i_valid <= 1'b0;
        no_idle = 1'b0;

        // drain
        wait (pending_moves.size() == 0);
        repeat (PIPE_DRAIN) @(negedge i_clk);
        if (errors == 0) begin
            $display("radial_brush_vertex_push verification clean");
        end else begin
            $display("radial_brush_vertex_push verification failed");
        end
        $finish;
    end

endmodule
